>>> sv/ccm_pkg.sv
// shared constants and types of the complex correlator mac
package ccm_pkg;

  localparam int unsigned SP_W      = 32;
  localparam int unsigned SP_MANT_W = 23;
  localparam int unsigned SP_BIAS   = 127;
  localparam logic [7:0]  SP_EXP_SPECIAL = 8'hFF;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

>>> sv/complex_correlator_mac.sv
// Complex correlator mac: one sample word (signal and code, four single-precision
// values and a final flag) is taken every clock cycle while full is low. Each value is
// floored and wrapped into signed fixed point of TOTAL_BITS bits with INT_BITS integer
// bits, the complex product is added into the real and imaginary accumulators, and the
// final word of a run puts both sums as single-precision words into the result queue and
// clears the accumulators. The accumulator add sets the rate of one word per cycle unless
// a full result queue stalls the stages. Full rises only when the sample queue of
// QUEUE_DEPTH words backs up behind an unread result queue.
module complex_correlator_mac #(
  parameter int unsigned TOTAL_BITS  = 18,
  parameter int unsigned INT_BITS    = 2,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] signal_real_i,
  input  logic [31:0] signal_imag_i,
  input  logic [31:0] code_real_i,
  input  logic [31:0] code_imag_i,
  input  logic        final_sample_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] sum_real_o,
  output logic [31:0] sum_imag_o
);

  localparam int unsigned MID_W = 4 * TOTAL_BITS + 1;

  ccm_pkg::fifo_status_t mid_st, out_st;
  logic                  mid_wr, mid_pop, out_wr;
  logic [MID_W-1:0]      mid_wr_data, mid_rd_data;
  logic [63:0]           out_wr_data, out_rd_data;

  ccm_front #(
    .TOTAL_BITS(TOTAL_BITS),
    .INT_BITS  (INT_BITS)
  ) u_front (
    .signal_real_i (signal_real_i),
    .signal_imag_i (signal_imag_i),
    .code_real_i   (code_real_i),
    .code_imag_i   (code_imag_i),
    .final_sample_i(final_sample_i),
    .push_i        (push),
    .full_i        (mid_st.full),
    .wr_o          (mid_wr),
    .wr_data_o     (mid_wr_data)
  );

  ccm_fifo #(
    .WIDTH(MID_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (mid_wr),
    .wr_data_i(mid_wr_data),
    .rd_i     (mid_pop),
    .rd_data_o(mid_rd_data),
    .status_o (mid_st)
  );

  ccm_back #(
    .TOTAL_BITS(TOTAL_BITS),
    .INT_BITS  (INT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mid_st_i  (mid_st),
    .mid_data_i(mid_rd_data),
    .mid_pop_o (mid_pop),
    .out_st_i  (out_st),
    .out_wr_o  (out_wr),
    .out_data_o(out_wr_data)
  );

  ccm_fifo #(
    .WIDTH(64),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (out_wr),
    .wr_data_i(out_wr_data),
    .rd_i     (pop),
    .rd_data_o(out_rd_data),
    .status_o (out_st)
  );

  assign full       = mid_st.full;
  assign empty      = out_st.empty;
  assign sum_real_o = out_rd_data[63:32];
  assign sum_imag_o = out_rd_data[31:0];

endmodule

>>> sv/ccm_fifo.sv
// small first-word-fall-through queue of words
module ccm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [WIDTH-1:0]      wr_data_i,
  input  logic                  rd_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output ccm_pkg::fifo_status_t status_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_ok, rd_ok;

  assign status_o.full  = (cnt_q == CW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign wr_ok = wr_i & ~status_o.full;
  assign rd_ok = rd_i & ~status_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_ok && !rd_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_ok && !wr_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> sv/ccm_front.sv
// front end: float to fixed conversion of the four samples and queue write
module ccm_front #(
  parameter int unsigned TOTAL_BITS = 18,
  parameter int unsigned INT_BITS   = 2
) (
  input  logic [31:0]             signal_real_i,
  input  logic [31:0]             signal_imag_i,
  input  logic [31:0]             code_real_i,
  input  logic [31:0]             code_imag_i,
  input  logic                    final_sample_i,
  input  logic                    push_i,
  input  logic                    full_i,
  output logic                    wr_o,
  output logic [4*TOTAL_BITS:0]   wr_data_o
);

  localparam int unsigned T = TOTAL_BITS;
  localparam int unsigned F = TOTAL_BITS - INT_BITS;
  localparam logic signed [9:0] SH_OFS = 10'(int'(F) - 150);
  localparam logic signed [9:0] T_S    = 10'(T);

  function automatic logic [T-1:0] flt_to_fix(input logic [31:0] x);
    logic [7:0]          ex;
    logic [23:0]         m;
    logic signed [9:0]   sh;
    logic [T+23:0]       wide;
    logic [T-1:0]        mag;
    logic                inexact;
    logic [4:0]          amt;
    ex      = x[ccm_pkg::SP_W-2:ccm_pkg::SP_MANT_W];
    m       = {ex != 8'd0, x[ccm_pkg::SP_MANT_W-1:0]};
    sh      = $signed({2'b00, (ex == 8'd0) ? 8'd1 : ex}) + SH_OFS;
    mag     = '0;
    inexact = 1'b0;
    amt     = '0;
    wide    = '0;
    if (ex == ccm_pkg::SP_EXP_SPECIAL) begin
      return '0;
    end
    if (sh >= 10'sd0) begin
      if (sh < T_S) begin
        wide = {{T{1'b0}}, m} << sh[4:0];
        mag  = wide[T-1:0];
      end
    end else if (sh > -10'sd24) begin
      amt     = 5'(-sh);
      wide    = {{T{1'b0}}, m} >> amt;
      mag     = wide[T-1:0];
      inexact = |(m & ~(24'hFFFFFF << amt));
    end else begin
      inexact = |m;
    end
    if (x[ccm_pkg::SP_W-1]) begin
      mag = inexact ? ~mag : (~mag + 1'b1);
    end
    return mag;
  endfunction

  assign wr_o      = push_i & ~full_i;
  assign wr_data_o = {flt_to_fix(signal_real_i), flt_to_fix(signal_imag_i),
                      flt_to_fix(code_real_i), flt_to_fix(code_imag_i), final_sample_i};

endmodule

>>> sv/ccm_back.sv
// back end: complex multiply, accumulate, and fixed to float conversion
module ccm_back #(
  parameter int unsigned TOTAL_BITS = 18,
  parameter int unsigned INT_BITS   = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ccm_pkg::fifo_status_t mid_st_i,
  input  logic [4*TOTAL_BITS:0] mid_data_i,
  output logic                  mid_pop_o,
  input  ccm_pkg::fifo_status_t out_st_i,
  output logic                  out_wr_o,
  output logic [63:0]           out_data_o
);

  localparam int unsigned T  = TOTAL_BITS;
  localparam int unsigned F  = TOTAL_BITS - INT_BITS;
  localparam int unsigned NW = $clog2(T);
  localparam logic [NW-1:0] MSB_POS = NW'(T - 1);
  localparam logic [7:0]    EXP_OFS = 8'(int'(ccm_pkg::SP_BIAS) - int'(F));

  function automatic logic [NW-1:0] msb_idx(input logic [T-1:0] v);
    logic [NW-1:0] idx;
    idx = '0;
    for (int i = 0; i < int'(T); i++) begin
      if (v[i]) idx = NW'(i);
    end
    return idx;
  endfunction

  function automatic logic [31:0] pack_flt(input logic sgn, input logic [T-1:0] mag,
                                           input logic [NW-1:0] n, input logic zero);
    logic [T+23:0] al;
    logic [23:0]   mant;
    logic [24:0]   mant_r;
    logic          up;
    logic [7:0]    ex;
    al     = {mag, 24'd0} << (MSB_POS - n);
    mant   = al[T+23:T];
    up     = al[T-1] & ((|al[T-2:0]) | mant[0]);
    mant_r = {1'b0, mant} + 25'(up);
    ex     = 8'(n) + EXP_OFS + 8'(mant_r[24]);
    return zero ? 32'd0 : {sgn, ex, mant_r[ccm_pkg::SP_MANT_W-1:0]};
  endfunction

  logic move;

  logic [T-1:0] a, b, c, d;
  logic         fin;

  logic                  p_vld_q, p_fin_q;
  logic signed [2*T-1:0] ac_q, bd_q, ad_q, bc_q;

  logic [T-1:0]   acc_re_q, acc_im_q;
  logic [T-1:0]   acc_re_n, acc_im_n;
  logic [2*T-1:0] pr, pi;
  logic           r_vld_q;
  logic [T-1:0]   r_re_q, r_im_q;

  logic          n_vld_q;
  logic          re_sgn_q, im_sgn_q, re_zero_q, im_zero_q;
  logic [T-1:0]  re_mag_q, im_mag_q;
  logic [NW-1:0] re_n_q, im_n_q;
  logic [T-1:0]  re_mag, im_mag;

  assign {a, b, c, d, fin} = mid_data_i;

  assign move      = ~n_vld_q | ~out_st_i.full;
  assign mid_pop_o = move & ~mid_st_i.empty;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (move) begin
      p_vld_q <= mid_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      p_fin_q <= fin;
      ac_q    <= $signed(a) * $signed(c);
      bd_q    <= $signed(b) * $signed(d);
      ad_q    <= $signed(a) * $signed(d);
      bc_q    <= $signed(b) * $signed(c);
    end
  end

  // accumulate stage
  assign pr       = ac_q - bd_q;
  assign pi       = ad_q + bc_q;
  assign acc_re_n = acc_re_q + pr[T+F-1:F];
  assign acc_im_n = acc_im_q + pi[T+F-1:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
      r_vld_q  <= 1'b0;
    end else if (move) begin
      r_vld_q <= p_vld_q & p_fin_q;
      if (p_vld_q) begin
        acc_re_q <= p_fin_q ? '0 : acc_re_n;
        acc_im_q <= p_fin_q ? '0 : acc_im_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && p_vld_q && p_fin_q) begin
      r_re_q <= acc_re_n;
      r_im_q <= acc_im_n;
    end
  end

  // magnitude and leading one stage
  assign re_mag = r_re_q[T-1] ? (~r_re_q + 1'b1) : r_re_q;
  assign im_mag = r_im_q[T-1] ? (~r_im_q + 1'b1) : r_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (move) begin
      n_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && r_vld_q) begin
      re_sgn_q  <= r_re_q[T-1];
      im_sgn_q  <= r_im_q[T-1];
      re_zero_q <= (r_re_q == '0);
      im_zero_q <= (r_im_q == '0);
      re_mag_q  <= re_mag;
      im_mag_q  <= im_mag;
      re_n_q    <= msb_idx(re_mag);
      im_n_q    <= msb_idx(im_mag);
    end
  end

  // normalize, round and hand the word to the result queue
  assign out_wr_o   = n_vld_q & move;
  assign out_data_o = {pack_flt(re_sgn_q, re_mag_q, re_n_q, re_zero_q),
                       pack_flt(im_sgn_q, im_mag_q, im_n_q, im_zero_q)};

endmodule

>>> verif/tb_complex_correlator_mac.sv
// self-checking testbench of the complex correlator mac with a bit-exact fixed-point predictor
module tb_complex_correlator_mac;

  localparam int TOTAL_W    = 18;
  localparam int FRAC_W     = 16;
  localparam int EXP_OFS    = int'(ccm_pkg::SP_BIAS) + int'(ccm_pkg::SP_MANT_W);
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 20;
  localparam int CYCLE_CAP  = 300000;

  typedef struct {
    logic [31:0] sig_re;
    logic [31:0] sig_im;
    logic [31:0] code_re;
    logic [31:0] code_im;
    logic        last;
  } sample_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
  } sum_pair_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [31:0] signal_real_i  = '0;
  logic [31:0] signal_imag_i  = '0;
  logic [31:0] code_real_i    = '0;
  logic [31:0] code_imag_i    = '0;
  logic        final_sample_i = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [31:0] sum_real_o;
  logic [31:0] sum_imag_o;

  sample_t          sample_queue[$];
  sum_pair_t        expected_sums[$];
  sample_t          cur_word;
  logic [TOTAL_W-1:0] acc_re = '0;
  logic [TOTAL_W-1:0] acc_im = '0;
  int unsigned      queued_cnt   = 0;
  int unsigned      accepted_cnt = 0;
  int unsigned      sums_checked = 0;
  int unsigned      full_stalls  = 0;
  int unsigned      err_cnt      = 0;
  int unsigned      cycle_cnt    = 0;
  int unsigned      send_gap     = 0;
  int unsigned      recv_hold    = 0;
  bit               idle_en      = 1'b1;
  bit               stall_req    = 1'b0;

  complex_correlator_mac dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .signal_real_i  (signal_real_i),
    .signal_imag_i  (signal_imag_i),
    .code_real_i    (code_real_i),
    .code_imag_i    (code_imag_i),
    .final_sample_i (final_sample_i),
    .empty          (empty),
    .pop            (pop),
    .sum_real_o     (sum_real_o),
    .sum_imag_o     (sum_imag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [TOTAL_W-1:0] float_to_fix(logic [31:0] x);
    int          ex;
    int          sh;
    logic [63:0] m;
    logic [63:0] mag;
    logic        inexact;
    if (x[30:23] == ccm_pkg::SP_EXP_SPECIAL) return '0;
    m       = {41'd0, x[ccm_pkg::SP_MANT_W-1:0]};
    ex      = int'(x[30:23]);
    inexact = 1'b0;
    if (ex == 0) begin
      ex = 1;
    end else begin
      m[ccm_pkg::SP_MANT_W] = 1'b1;
    end
    sh = ex - EXP_OFS + FRAC_W;
    if (sh >= 0) begin
      mag = (sh < 64) ? (m << sh) : '0;
    end else if (-sh >= 64) begin
      mag     = '0;
      inexact = (m != 0);
    end else begin
      mag     = m >> (-sh);
      inexact = ((m & ((64'd1 << (-sh)) - 64'd1)) != 0);
    end
    if (x[31]) begin
      mag = -mag - {63'd0, inexact};
    end
    return mag[TOTAL_W-1:0];
  endfunction

  function automatic logic [31:0] fix_to_float(logic [TOTAL_W-1:0] v);
    logic [TOTAL_W-1:0] mag;
    logic [47:0]        norm;
    int                 msb;
    if (v == '0) return '0;
    mag = v[TOTAL_W-1] ? -v : v;
    msb = 0;
    for (int i = 0; i < TOTAL_W; i++) begin
      if (mag[i]) msb = i;
    end
    norm = {30'd0, mag} << (ccm_pkg::SP_MANT_W - msb);
    return {v[TOTAL_W-1], 8'(msb - FRAC_W + int'(ccm_pkg::SP_BIAS)),
            norm[ccm_pkg::SP_MANT_W-1:0]};
  endfunction

  task automatic accumulate_sample(sample_t s);
    logic signed [TOTAL_W-1:0] fa;
    logic signed [TOTAL_W-1:0] fb;
    logic signed [TOTAL_W-1:0] fc;
    logic signed [TOTAL_W-1:0] fd;
    logic [63:0]               pr;
    logic [63:0]               pi;
    sum_pair_t                 res;
    fa = float_to_fix(s.sig_re);
    fb = float_to_fix(s.sig_im);
    fc = float_to_fix(s.code_re);
    fd = float_to_fix(s.code_im);
    pr = longint'(fa) * longint'(fc) - longint'(fb) * longint'(fd);
    pi = longint'(fa) * longint'(fd) + longint'(fb) * longint'(fc);
    acc_re = acc_re + pr[FRAC_W +: TOTAL_W];
    acc_im = acc_im + pi[FRAC_W +: TOTAL_W];
    if (s.last) begin
      res.re = fix_to_float(acc_re);
      res.im = fix_to_float(acc_im);
      expected_sums.push_back(res);
      acc_re = '0;
      acc_im = '0;
    end
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] r;
    int          sel;
    r   = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 55) r[30:23] = 8'($urandom_range(108, 128));
    else if (sel < 65) r[30:23] = 8'($urandom_range(0, 107));
    else if (sel < 72) r[30:23] = 8'($urandom_range(129, 160));
    else if (sel < 75) r[30:0] = '0;
    else if (sel < 79) r[30:23] = ccm_pkg::SP_EXP_SPECIAL;
    else if (sel < 83) r[30:23] = 8'h00;
    return r;
  endfunction

  task automatic add_sample(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                            logic last);
    sample_t s;
    s.sig_re  = a;
    s.sig_im  = b;
    s.code_re = c;
    s.code_im = d;
    s.last    = last;
    sample_queue.push_back(s);
    queued_cnt++;
  endtask

  task automatic add_runs(int unsigned n_items, int unsigned max_len);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : $urandom_range(1, max_len);
      for (int unsigned i = 0; i < len; i++) begin
        add_sample(rand_float(), rand_float(), rand_float(), rand_float(), i == len - 1);
      end
      added += len;
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_sums.size() != 0) @(posedge clk_i);
  endtask

  // sender of sample words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && full) full_stalls++;
      if (push && !full) begin
        accumulate_sample(cur_word);
        accepted_cnt++;
      end
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          push     <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 13);
          push     <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          cur_word        = sample_queue.pop_front();
          signal_real_i  <= cur_word.sig_re;
          signal_imag_i  <= cur_word.sig_im;
          code_real_i    <= cur_word.code_re;
          code_imag_i    <= cur_word.code_im;
          final_sample_i <= cur_word.last;
          push           <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver of result words
  always @(posedge clk_i or negedge rst_ni) begin
    sum_pair_t exp_sum;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        sums_checked++;
        if (expected_sums.size() == 0) begin
          $error("unexpected result word: sum_real %h sum_imag %h", sum_real_o, sum_imag_o);
          err_cnt++;
        end else begin
          exp_sum = expected_sums.pop_front();
          if (sum_real_o !== exp_sum.re) begin
            $error("sum_real mismatch: expected %h, actual %h", exp_sum.re, sum_real_o);
            err_cnt++;
          end
          if (sum_imag_o !== exp_sum.im) begin
            $error("sum_imag mismatch: expected %h, actual %h", exp_sum.im, sum_imag_o);
            err_cnt++;
          end
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        recv_hold <= LONG_HOLD;
        pop       <= 1'b0;
      end else if (recv_hold != 0) begin
        recv_hold <= recv_hold - 1;
        pop       <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        recv_hold <= $urandom_range(0, 13);
        pop       <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("complex_correlator_mac regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero, unit and wrap of the largest operands
    add_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    add_sample(32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 1'b1);
    add_sample(32'h3FFF_FFFF, 32'hC000_0000, 32'h3FFF_FFFF, 32'hC000_0000, 1'b1);
    // nan and infinity taken as zero
    add_sample(32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF, 1'b1);
    add_sample(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
    // negative zero and subnormals
    add_sample(32'h8000_0000, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 1'b1);
    add_sample(32'h8000_0001, 32'h3F80_0000, 32'h3F80_0000, 32'h807F_FFFF, 1'b1);
    // out of range values wrap
    add_sample(32'h4B00_0000, 32'h4080_0000, 32'hC080_0000, 32'h3F7F_FFFF, 1'b1);
    add_sample(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4040_0000, 32'hBFC0_0000, 1'b1);
    // one lsb and floor of tiny negatives
    add_sample(32'h3780_0000, 32'hB780_0000, 32'h3F80_0000, 32'hB580_0000, 1'b1);
    // accumulator overflow over a longer run
    for (int i = 0; i < 4; i++) begin
      add_sample(32'h3FF0_0000, 32'hBFF0_0000, 32'h3FF0_0000, 32'h3FF0_0000, 1'b0);
    end
    add_sample(32'h3FF0_0000, 32'h3FF0_0000, 32'hBFF0_0000, 32'h3FF0_0000, 1'b1);
    add_sample(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
    add_sample(32'h3F80_0000, 32'hBF80_0000, 32'hBF80_0000, 32'h3F80_0000, 1'b1);
    wait_drained();

    add_runs(1100, 8);
    wait_drained();

    // long receiver hold with short runs so the block backs up
    stall_req = 1'b1;
    add_runs(80, 2);
    wait_drained();

    add_runs(250, 12);
    wait_drained();

    idle_en = 1'b0;
    add_runs(200, 8);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d sample words and %0d correlation sums", accepted_cnt, sums_checked);
    $display("input held off by full on %0d cycles", full_stalls);
    if (err_cnt == 0 && expected_sums.size() == 0) begin
      $display("complex_correlator_mac regression: pass");
    end else begin
      $display("complex_correlator_mac regression: fail");
    end
    $finish;
  end

endmodule
